// ===== hw/rtl/fcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcdc_pkg
// Shared constants, command/status types and helpers of the fan curve duty
// controller.
// ----------------------------------------------------------------------------
package fcdc_pkg;

    localparam int NUM_LEVELS = 10;
    localparam int HALF_LEVELS = NUM_LEVELS / 2;
    localparam int IDX_W = $clog2(NUM_LEVELS);
    localparam int ENTRY_W = 7;
    localparam int PACK_W = ENTRY_W * HALF_LEVELS;
    localparam int TT_W = 4;
    localparam int TEMP_W = 7;
    localparam int RAW_W = 8;
    localparam int HOLD_W = 8;
    localparam int LVL_W = 4;
    localparam int PWM_W = 8;
    localparam int DIV_W = 16;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int CFG_IDX_W = 3;

    localparam logic [ENTRY_W-1:0] DUTY_MAX = 7'd100;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LEVELS - 1);
    localparam logic [IDX_W-1:0] IDX_LIN_START = IDX_W'(NUM_LEVELS - 2);
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(NUM_LEVELS);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_THR_UPPER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOWER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_UPPER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LOWER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_TEMP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SOFT = 3'd6;

    localparam logic [PACK_W-1:0] THR_UPPER_RST = 35'd18949090010;
    localparam logic [PACK_W-1:0] THR_LOWER_RST = 35'd12185361985;
    localparam logic [PACK_W-1:0] DUTY_UPPER_RST = 35'd9511741535;
    localparam logic [PACK_W-1:0] DUTY_LOWER_RST = 35'd4869885086;
    localparam logic [TT_W-1:0] TRANS_TEMP_RST = 4'd3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic mul;
        logic prep;
        logic div;
        logic quot;
        logic commit;
    } fcdc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic interp;
        logic div_done;
        logic out_free;
    } fcdc_stat_t;

    function automatic logic [ENTRY_W-1:0] clamp_duty(input logic [ENTRY_W-1:0] d);
        clamp_duty = (d > DUTY_MAX) ? DUTY_MAX : d;
    endfunction

    // (510*d + 100) / 200 == ((51*d + 10) >> 2) / 5, the last by reciprocal
    function automatic logic [PWM_W-1:0] to_pwm(input logic [ENTRY_W-1:0] d);
        logic [12:0] s;
        logic [24:0] p;
        s = 13'(d) * 13'd51 + 13'd10;
        p = 25'(s[12:2]) * 25'd13108;
        to_pwm = p[23:16];
    endfunction

    // (200*raw + 255) / 510 == floor(y / 255) with y = (200*raw + 255) >> 1
    function automatic logic [ENTRY_W-1:0] to_percent(input logic [RAW_W-1:0] raw);
        logic [15:0] x;
        logic [14:0] y;
        logic [14:0] s;
        x = 16'(raw) * 16'd200 + 16'd255;
        y = x[15:1];
        s = y + (y >> 8) + 15'd1;
        to_percent = s[14:8];
    endfunction

endpackage

// ===== hw/rtl/fcdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcdc_ctrl
// Sequencer of the duty controller: accept, curve scan, interpolation
// multiply and divide, commit into the output register.
// ----------------------------------------------------------------------------
module fcdc_ctrl
    import fcdc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       req_type,
    output logic       in_ready,
    input  fcdc_stat_t stat,
    output fcdc_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_PREP = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_QUOT = 7'b0100000,
        S_FIN  = 7'b1000000
    } fcdc_state_t;

    fcdc_state_t state_reg;
    fcdc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = (req_type == REQ_TICK) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = stat.interp ? S_MUL : S_FIN;
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (stat.div_done)
                begin
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                cmd.quot = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/fcdc_dp.sv =====
// ----------------------------------------------------------------------------
// fcdc_dp
// Datapath of the duty controller: configuration, channel state, curve
// lookup, interpolation with a bit-serial divider, output register.
// ----------------------------------------------------------------------------
module fcdc_dp
    import fcdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PACK_W-1:0]    cfg_data,
    input  logic                 req_type,
    input  logic [TEMP_W-1:0]    temperature,
    input  logic [RAW_W-1:0]     measured_raw,
    input  fcdc_cmd_t            cmd,
    output fcdc_stat_t           stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 write_valid,
    output logic [PWM_W-1:0]     pwm_value,
    output logic [ENTRY_W-1:0]   duty_percent,
    output logic [LVL_W-1:0]     level
);

    logic [PACK_W-1:0]  thr_up_reg;
    logic [PACK_W-1:0]  thr_lo_reg;
    logic [PACK_W-1:0]  dut_up_reg;
    logic [PACK_W-1:0]  dut_lo_reg;
    logic [TT_W-1:0]    tt_reg;
    logic               lin_reg;
    logic               soft_reg;

    logic [HOLD_W-1:0]  hold_reg;
    logic [LVL_W-1:0]   last_level_reg;
    logic [ENTRY_W-1:0] set_duty_reg;
    logic [ENTRY_W-1:0] meas_reg;
    logic [ENTRY_W-1:0] ramp_cur_reg;
    logic [ENTRY_W-1:0] ramp_tgt_reg;
    logic               out_valid_reg;

    logic               req_reg;
    logic [HOLD_W-1:0]  j_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [LVL_W-1:0]   lvl_new_reg;
    logic [ENTRY_W-1:0] duty_new_reg;
    logic signed [16:0] prod_reg;
    logic [ENTRY_W-1:0] den_reg;
    logic               sign_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [7:0]         rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               wv_reg;
    logic [PWM_W-1:0]   pwm_reg;
    logic [ENTRY_W-1:0] duty_out_reg;
    logic [LVL_W-1:0]   lvl_out_reg;

    logic [ENTRY_W-1:0] thr_arr [NUM_LEVELS];
    logic [ENTRY_W-1:0] dut_arr [NUM_LEVELS];

    always_comb
    begin
        for (int i = 0; i < HALF_LEVELS; i++)
        begin
            thr_arr[i] = thr_up_reg[ENTRY_W*i +: ENTRY_W];
            thr_arr[i+HALF_LEVELS] = thr_lo_reg[ENTRY_W*i +: ENTRY_W];
            dut_arr[i] = dut_up_reg[ENTRY_W*i +: ENTRY_W];
            dut_arr[i+HALF_LEVELS] = dut_lo_reg[ENTRY_W*i +: ENTRY_W];
        end
    end

    // temperature with falling hold
    logic [HOLD_W-1:0] t_ext;
    logic [HOLD_W-1:0] t_top;
    logic [HOLD_W-1:0] h_low;
    logic [HOLD_W-1:0] h_val;
    logic [HOLD_W-1:0] j_load;

    assign t_ext = HOLD_W'(temperature);
    assign t_top = t_ext + HOLD_W'(tt_reg);
    assign h_low = (hold_reg < t_ext) ? t_ext : hold_reg;
    assign h_val = (h_low > t_top) ? t_top : h_low;
    assign j_load = lin_reg ? h_val : t_ext;

    // curve scan
    logic [IDX_W-1:0]   k_up;
    logic [HOLD_W-1:0]  thr_k;
    logic               step_brk;
    logic               below;
    logic               above;
    logic               lin_done;
    logic               scan_done;
    logic               interp;

    assign k_up = k_reg + IDX_W'(1);
    assign thr_k = HOLD_W'(thr_arr[k_reg]);
    assign step_brk = (j_reg >= thr_k)
        || (((9'(j_reg) + 9'(tt_reg)) >= 9'(thr_k))
            && ((5'(last_level_reg) + 5'(k_reg)) >= 5'(NUM_LEVELS)));
    assign below = j_reg < HOLD_W'(thr_arr[IDX_LAST]);
    assign above = j_reg >= HOLD_W'(thr_arr[0]);
    assign lin_done = below || above || (j_reg < thr_k);
    assign scan_done = lin_reg ? lin_done : (step_brk || (k_reg == IDX_LAST));
    assign interp = lin_reg && !below && !above;

    // interpolation operands
    logic [ENTRY_W-1:0] tl;
    logic [ENTRY_W-1:0] dl;
    logic signed [7:0]  ddiff;
    logic signed [8:0]  jd_s;
    logic signed [16:0] prod_c;
    logic signed [18:0] n_val;
    logic [18:0]        n_mag;
    logic [7:0]         divisor;
    logic [8:0]         trial;
    logic               ge;
    logic signed [16:0] q_s;
    logic signed [16:0] q_sum;
    logic [ENTRY_W-1:0] q_duty;

    assign tl = thr_arr[k_up];
    assign dl = dut_arr[k_up];
    assign ddiff = $signed({1'b0, dut_arr[k_reg]}) - $signed({1'b0, dl});
    assign jd_s = $signed({1'b0, j_reg - HOLD_W'(tl)});
    assign prod_c = ddiff * jd_s;
    assign n_val = ($signed({{2{prod_reg[16]}}, prod_reg}) <<< 1)
        + $signed({12'd0, den_reg});
    assign n_mag = n_val[18] ? 19'(-n_val) : 19'(n_val);
    assign divisor = {den_reg, 1'b0};
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge = trial >= {1'b0, divisor};
    assign q_s = sign_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign q_sum = q_s + $signed({10'd0, dl});
    assign q_duty = (q_sum < 0) ? '0
        : ((q_sum > $signed(17'(DUTY_MAX))) ? DUTY_MAX : q_sum[ENTRY_W-1:0]);

    // commit
    logic               ramp_move;
    logic [ENTRY_W-1:0] ramp_step;
    logic [ENTRY_W-1:0] set_duty_next;
    logic [LVL_W-1:0]   last_level_next;
    logic [HOLD_W-1:0]  hold_next;
    logic [ENTRY_W-1:0] ramp_cur_next;
    logic [ENTRY_W-1:0] ramp_tgt_next;
    logic               wv_next;

    assign ramp_move = soft_reg && (ramp_cur_reg != ramp_tgt_reg);
    assign ramp_step = (ramp_cur_reg < ramp_tgt_reg) ? ramp_cur_reg + ENTRY_W'(1)
                                                     : ramp_cur_reg - ENTRY_W'(1);

    always_comb
    begin
        set_duty_next = set_duty_reg;
        last_level_next = last_level_reg;
        hold_next = hold_reg;
        ramp_cur_next = ramp_cur_reg;
        ramp_tgt_next = ramp_tgt_reg;
        wv_next = 1'b0;
        if (req_reg == REQ_SAMPLE)
        begin
            set_duty_next = duty_new_reg;
            last_level_next = lvl_new_reg;
            if (lin_reg)
            begin
                hold_next = j_reg;
            end
            if (soft_reg)
            begin
                ramp_tgt_next = duty_new_reg;
                if (ramp_cur_reg == '0)
                begin
                    ramp_cur_next = meas_reg;
                end
            end
            else
            begin
                wv_next = meas_reg != duty_new_reg;
            end
        end
        else if (ramp_move)
        begin
            ramp_cur_next = ramp_step;
            set_duty_next = ramp_step;
            wv_next = meas_reg != ramp_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_up_reg <= THR_UPPER_RST;
            thr_lo_reg <= THR_LOWER_RST;
            dut_up_reg <= DUTY_UPPER_RST;
            dut_lo_reg <= DUTY_LOWER_RST;
            tt_reg <= TRANS_TEMP_RST;
            lin_reg <= 1'b0;
            soft_reg <= 1'b0;
            hold_reg <= '0;
            last_level_reg <= '0;
            set_duty_reg <= '0;
            meas_reg <= '0;
            ramp_cur_reg <= '0;
            ramp_tgt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THR_UPPER:  thr_up_reg <= cfg_data;
                    CFG_THR_LOWER:  thr_lo_reg <= cfg_data;
                    CFG_DUTY_UPPER: dut_up_reg <= cfg_data;
                    CFG_DUTY_LOWER: dut_lo_reg <= cfg_data;
                    CFG_TRANS_TEMP: tt_reg <= cfg_data[TT_W-1:0];
                    CFG_LINEAR:     lin_reg <= cfg_data[0];
                    CFG_SOFT:       soft_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (cmd.load && (req_type == REQ_SAMPLE))
            begin
                meas_reg <= to_percent(measured_raw);
            end
            if (cmd.commit)
            begin
                hold_reg <= hold_next;
                last_level_reg <= last_level_next;
                set_duty_reg <= set_duty_next;
                ramp_cur_reg <= ramp_cur_next;
                ramp_tgt_reg <= ramp_tgt_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            j_reg <= j_load;
            k_reg <= lin_reg ? IDX_LIN_START : '0;
        end
        if (cmd.scan)
        begin
            if (scan_done)
            begin
                if (!lin_reg)
                begin
                    duty_new_reg <= clamp_duty(dut_arr[k_reg]);
                    lvl_new_reg <= LVL_TOP - LVL_W'(k_reg);
                end
                else if (below)
                begin
                    duty_new_reg <= clamp_duty(dut_arr[IDX_LAST]);
                    lvl_new_reg <= '0;
                end
                else if (above)
                begin
                    duty_new_reg <= clamp_duty(dut_arr[0]);
                    lvl_new_reg <= LVL_TOP;
                end
                else
                begin
                    lvl_new_reg <= LVL_W'(IDX_LAST) - LVL_W'(k_reg);
                end
            end
            else if (lin_reg)
            begin
                k_reg <= k_reg - IDX_W'(1);
            end
            else
            begin
                k_reg <= k_up;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_c;
            den_reg <= thr_arr[k_reg] - tl;
        end
        if (cmd.prep)
        begin
            sign_reg <= n_val[18];
            quo_reg <= n_mag[DIV_W-1:0];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div)
        begin
            rem_reg <= ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.quot)
        begin
            duty_new_reg <= q_duty;
        end
        if (cmd.commit)
        begin
            wv_reg <= wv_next;
            pwm_reg <= to_pwm(set_duty_next);
            duty_out_reg <= set_duty_next;
            lvl_out_reg <= last_level_next;
        end
    end

    assign stat.scan_done = scan_done;
    assign stat.interp = interp;
    assign stat.div_done = cnt_reg == CNT_W'(DIV_W - 1);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign write_valid = wv_reg;
    assign pwm_value = pwm_reg;
    assign duty_percent = duty_out_reg;
    assign level = lvl_out_reg;

endmodule

// ===== hw/rtl/fan_curve_duty_controller.sv =====
// ----------------------------------------------------------------------------
// fan_curve_duty_controller
// One fan channel: stepped or interpolated duty curve with hysteresis,
// optional soft ramp, PWM byte output.
// ----------------------------------------------------------------------------
// Sequence: a ramp tick goes from accept straight to commit; a sample first
// scans the curve levels, and a linear sample between two curve points then
// runs the interpolation multiply and the bit-serial divider before its commit.
// Throughput: one item at a time; the next item is taken while a result
// waits in the output register.
// Reset: curve registers take their defaults, channel state clears to zero.
// ----------------------------------------------------------------------------
module fan_curve_duty_controller
    import fcdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PACK_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [TEMP_W-1:0]    temperature,
    input  logic [RAW_W-1:0]     measured_raw,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 write_valid,
    output logic [PWM_W-1:0]     pwm_value,
    output logic [ENTRY_W-1:0]   duty_percent,
    output logic [LVL_W-1:0]     level
);

    fcdc_cmd_t  cmd;
    fcdc_stat_t stat;

    fcdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcdc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .temperature  (temperature),
        .measured_raw (measured_raw),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .write_valid  (write_valid),
        .pwm_value    (pwm_value),
        .duty_percent (duty_percent),
        .level        (level)
    );

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (duty_percent <= DUTY_MAX))
        else $error("duty out of range");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level <= LVL_TOP))
        else $error("level out of range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

endmodule

// ===== tb/fan_curve_duty_controller_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve duty controller checker
// Watches the configuration port and both channels of the block. It keeps
// its own copy of the curve registers and channel state, works out the duty
// result of every input transfer and compares each output transfer with the
// oldest outstanding duty result, field by field.
// ----------------------------------------------------------------------------
module fan_curve_duty_controller_checker
    import fcdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PACK_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 req_type,
    input  logic [TEMP_W-1:0]    temperature,
    input  logic [RAW_W-1:0]     measured_raw,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 write_valid,
    input  logic [PWM_W-1:0]     pwm_value,
    input  logic [ENTRY_W-1:0]   duty_percent,
    input  logic [LVL_W-1:0]     level,
    output int                   mismatches,
    output int                   pending,
    output int                   results_seen
);

    typedef struct packed {
        logic                write;
        logic [PWM_W-1:0]    pwm;
        logic [ENTRY_W-1:0]  duty;
        logic [LVL_W-1:0]    lvl;
    } fan_result_t;

    logic [PACK_W-1:0]  thr_hi;
    logic [PACK_W-1:0]  thr_lo;
    logic [PACK_W-1:0]  duty_hi;
    logic [PACK_W-1:0]  duty_lo;
    logic [TT_W-1:0]    band;
    logic               lin_on;
    logic               soft_on;

    logic [HOLD_W-1:0]  hold_temp;
    logic [LVL_W-1:0]   last_level;
    logic [ENTRY_W-1:0] set_duty;
    logic [ENTRY_W-1:0] meas_duty;
    logic [ENTRY_W-1:0] ramp_cur;
    logic [ENTRY_W-1:0] ramp_tgt;

    fan_result_t duty_q[$];

    function automatic int entry_of(input logic [PACK_W-1:0] hi, input logic [PACK_W-1:0] lo,
                                    input int k);
        logic [PACK_W-1:0] w;
        w = (k < HALF_LEVELS) ? hi : lo;
        return int'(w[ENTRY_W * (k % HALF_LEVELS) +: ENTRY_W]);
    endfunction

    function automatic int threshold_at(input int k);
        return entry_of(thr_hi, thr_lo, k);
    endfunction

    function automatic int duty_at(input int k);
        return entry_of(duty_hi, duty_lo, k);
    endfunction

    function automatic logic [ENTRY_W-1:0] saturate(input longint d);
        if (d < 0)
        begin
            return '0;
        end
        if (d > longint'(DUTY_MAX))
        begin
            return DUTY_MAX;
        end
        return ENTRY_W'(d);
    endfunction

    function automatic fan_result_t predict_duty(input logic rt, input logic [TEMP_W-1:0] temp,
                                                 input logic [RAW_W-1:0] raw);
        fan_result_t r;
        int          t;
        int          tt;
        int          k;
        int          lv;
        int          h;
        int          idx;
        int          m;
        logic        found;
        longint      tl;
        longint      th;
        longint      dl;
        longint      dh;
        longint      num;
        longint      den;
        longint      q;
        r.write = 1'b0;
        if (rt == REQ_SAMPLE)
        begin
            t = int'(temp);
            tt = int'(band);
            meas_duty = ENTRY_W'((int'(raw) * 200 + 255) / 510);
            if (!lin_on)
            begin
                k = 0;
                lv = 1;
                found = 1'b0;
                while (!found && k < NUM_LEVELS)
                begin
                    lv = NUM_LEVELS - k;
                    if (t >= threshold_at(k) ||
                        (t >= threshold_at(k) - tt && int'(last_level) >= lv))
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        k++;
                    end
                end
                if (k > NUM_LEVELS - 1)
                begin
                    k = NUM_LEVELS - 1;
                end
                set_duty = saturate(duty_at(k));
                last_level = LVL_W'(lv);
            end
            else
            begin
                h = int'(hold_temp);
                if (h < t)
                begin
                    h = t;
                end
                if (h > t + tt)
                begin
                    h = t + tt;
                end
                hold_temp = HOLD_W'(h);
                if (h < threshold_at(NUM_LEVELS - 1))
                begin
                    set_duty = saturate(duty_at(NUM_LEVELS - 1));
                    last_level = '0;
                end
                else if (h >= threshold_at(0))
                begin
                    set_duty = saturate(duty_at(0));
                    last_level = LVL_TOP;
                end
                else
                begin
                    idx = 0;
                    for (m = NUM_LEVELS - 2; m >= 1; m--)
                    begin
                        if (idx == 0 && h < threshold_at(m))
                        begin
                            idx = m;
                        end
                    end
                    tl = threshold_at(idx + 1);
                    th = threshold_at(idx);
                    dl = duty_at(idx + 1);
                    dh = duty_at(idx);
                    den = th - tl;
                    if (den == 0)
                    begin
                        q = 0;
                    end
                    else
                    begin
                        num = (dh - dl) * (longint'(h) - tl);
                        q = (2 * num + den) / (2 * den);
                    end
                    set_duty = saturate(q + dl);
                    last_level = LVL_W'(NUM_LEVELS - 1 - idx);
                end
            end
            if (soft_on)
            begin
                ramp_tgt = set_duty;
                if (ramp_cur == '0)
                begin
                    ramp_cur = meas_duty;
                end
            end
            else
            begin
                r.write = (meas_duty != set_duty);
            end
        end
        else if (soft_on && ramp_cur != ramp_tgt)
        begin
            if (ramp_cur < ramp_tgt)
            begin
                ramp_cur = ramp_cur + 1'b1;
            end
            else
            begin
                ramp_cur = ramp_cur - 1'b1;
            end
            set_duty = ramp_cur;
            r.write = (meas_duty != set_duty);
        end
        r.pwm = PWM_W'((int'(set_duty) * 510 + 100) / 200);
        r.duty = set_duty;
        r.lvl = last_level;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("duty result %0d, %s: got %0d, expected %0d", results_seen, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        fan_result_t want;
        if (!rst_n)
        begin
            thr_hi = THR_UPPER_RST;
            thr_lo = THR_LOWER_RST;
            duty_hi = DUTY_UPPER_RST;
            duty_lo = DUTY_LOWER_RST;
            band = TRANS_TEMP_RST;
            lin_on = 1'b0;
            soft_on = 1'b0;
            hold_temp = '0;
            last_level = '0;
            set_duty = '0;
            meas_duty = '0;
            ramp_cur = '0;
            ramp_tgt = '0;
            duty_q.delete();
            mismatches = 0;
            results_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THR_UPPER:  thr_hi = cfg_data;
                    CFG_THR_LOWER:  thr_lo = cfg_data;
                    CFG_DUTY_UPPER: duty_hi = cfg_data;
                    CFG_DUTY_LOWER: duty_lo = cfg_data;
                    CFG_TRANS_TEMP: band = cfg_data[TT_W-1:0];
                    CFG_LINEAR:     lin_on = cfg_data[0];
                    CFG_SOFT:       soft_on = cfg_data[0];
                    default:        ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (duty_q.size() == 0)
                begin
                    report_mismatch("unexpected transfer, duty", int'(duty_percent), -1);
                end
                else
                begin
                    want = duty_q.pop_front();
                    if (write_valid !== want.write)
                    begin
                        report_mismatch("write_valid", int'(write_valid), int'(want.write));
                    end
                    if (pwm_value !== want.pwm)
                    begin
                        report_mismatch("pwm_value", int'(pwm_value), int'(want.pwm));
                    end
                    if (duty_percent !== want.duty)
                    begin
                        report_mismatch("duty_percent", int'(duty_percent), int'(want.duty));
                    end
                    if (level !== want.lvl)
                    begin
                        report_mismatch("level", int'(level), int'(want.lvl));
                    end
                end
                results_seen++;
            end
            if (in_valid && in_ready)
            begin
                duty_q.push_back(predict_duty(req_type, temperature, measured_raw));
            end
            pending <= duty_q.size();
        end
    end

endmodule

// ===== tb/fan_curve_duty_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan curve duty controller test
// Drives samples and ramp ticks into the controller: a directed opening over
// the curve edges, hysteresis, interpolation, saturation and soft ramping,
// then random temperature walks under a series of curve settings, with
// random stalls on both channels in all but the last third of them. A checker beside the block predicts and
// compares every duty result.
// ----------------------------------------------------------------------------
module fan_curve_duty_controller_test;
    import fcdc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int SETTINGS_RUN = 12;
    localparam int ITEMS_PER_SETTING = 52;
    localparam int DRAIN_CYCLES = 40;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PACK_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_type = REQ_SAMPLE;
    logic [TEMP_W-1:0]    temperature = '0;
    logic [RAW_W-1:0]     measured_raw = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 write_valid;
    logic [PWM_W-1:0]     pwm_value;
    logic [ENTRY_W-1:0]   duty_percent;
    logic [LVL_W-1:0]     level;

    int mismatches;
    int pending;
    int results_seen;
    int send_idle_pct = 27;
    int recv_idle_pct = 64;
    int samples_sent = 0;
    int ticks_sent = 0;
    int settings_used = 0;
    int pwm_writes = 0;
    logic [ENTRY_W-1:0] last_duty_seen = '0;

    fan_curve_duty_controller DUT (.*);

    fan_curve_duty_controller_checker checker_i (.*);

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            last_duty_seen <= duty_percent;
            if (write_valid)
            begin
                pwm_writes++;
            end
        end
    end

    task automatic wait_drained();
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PACK_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_curve(input logic [PACK_W-1:0] thr_u, input logic [PACK_W-1:0] thr_l,
                               input logic [PACK_W-1:0] duty_u, input logic [PACK_W-1:0] duty_l,
                               input logic [TT_W-1:0] tt, input logic lin,
                               input logic soft_sel);
        wait_drained();
        write_reg(CFG_THR_UPPER, thr_u);
        write_reg(CFG_THR_LOWER, thr_l);
        write_reg(CFG_DUTY_UPPER, duty_u);
        write_reg(CFG_DUTY_LOWER, duty_l);
        write_reg(CFG_TRANS_TEMP, PACK_W'(tt));
        write_reg(CFG_LINEAR, PACK_W'(lin));
        write_reg(CFG_SOFT, PACK_W'(soft_sel));
        settings_used++;
    endtask

    task automatic send_item(input logic rt, input logic [TEMP_W-1:0] t,
                             input logic [RAW_W-1:0] raw);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = rt;
        temperature = t;
        measured_raw = raw;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b0;
        if (rt == REQ_SAMPLE)
        begin
            samples_sent++;
        end
        else
        begin
            ticks_sent++;
        end
    endtask

    initial
    begin : stimulus
        logic [PACK_W-1:0] packs [4];
        logic [RAW_W-1:0]  raw;
        logic              soft_sel;
        int                v;
        int                walk;
        int                s;
        int                i;
        int                k;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stepped curve at reset values, hysteresis around the top levels
        send_item(REQ_SAMPLE, 7'd0, 8'd0);
        send_item(REQ_SAMPLE, 7'd127, 8'd255);
        send_item(REQ_SAMPLE, 7'd90, 8'd0);
        send_item(REQ_SAMPLE, 7'd88, 8'd128);
        send_item(REQ_SAMPLE, 7'd86, 8'd200);
        send_item(REQ_SAMPLE, 7'd88, 8'd170);
        send_item(REQ_SAMPLE, 7'd63, 8'd100);
        send_item(REQ_SAMPLE, 7'd0, 8'd255);
        send_item(REQ_TICK, 7'd127, 8'd255);

        // linear curve with the widest falling hold
        wait_drained();
        write_reg(CFG_LINEAR, PACK_W'(1));
        write_reg(CFG_TRANS_TEMP, PACK_W'(15));
        settings_used++;
        send_item(REQ_SAMPLE, 7'd127, 8'd255);
        send_item(REQ_SAMPLE, 7'd100, 8'd240);
        send_item(REQ_SAMPLE, 7'd67, 8'd77);
        send_item(REQ_SAMPLE, 7'd30, 8'd50);
        send_item(REQ_SAMPLE, 7'd0, 8'd0);

        // equal neighboring thresholds, duties past full scale, spare index
        wait_drained();
        write_reg(CFG_SPARE, '1);
        apply_curve({7'd60, 7'd80, 7'd80, 7'd100, 7'd100},
                    {7'd20, 7'd20, 7'd40, 7'd40, 7'd60},
                    {7'd90, 7'd101, 7'd110, 7'd120, 7'd127},
                    {7'd0, 7'd20, 7'd40, 7'd60, 7'd80},
                    4'd0, 1'b1, 1'b0);
        send_item(REQ_SAMPLE, 7'd90, 8'd10);
        send_item(REQ_SAMPLE, 7'd127, 8'd255);
        send_item(REQ_SAMPLE, 7'd70, 8'd128);
        wait_drained();
        write_reg(CFG_LINEAR, PACK_W'(0));
        send_item(REQ_SAMPLE, 7'd100, 8'd64);

        // soft ramp: load from the measured duty, then creep toward target
        wait_drained();
        write_reg(CFG_SOFT, PACK_W'(1));
        send_item(REQ_SAMPLE, 7'd0, 8'd100);
        for (k = 0; k < 4; k++)
        begin
            send_item(REQ_TICK, 7'd0, 8'd0);
        end
        send_item(REQ_SAMPLE, 7'd127, 8'd255);
        send_item(REQ_TICK, 7'd127, 8'd255);

        walk = 60;
        for (s = 0; s < SETTINGS_RUN; s++)
        begin
            if (s == SETTINGS_RUN / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 27;
            end
            else if (s == 2 * SETTINGS_RUN / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (s == 0)
            begin
                apply_curve('0, '0, '1, '1, 4'd0, 1'b0, 1'b0);
            end
            else if (s == 1)
            begin
                apply_curve('1, '1, '0, '0, 4'd15, 1'b1, 1'b1);
            end
            else
            begin
                if ($urandom_range(4, 0) == 0)
                begin
                    for (k = 0; k < 4; k++)
                    begin
                        packs[k] = PACK_W'({$urandom, $urandom});
                    end
                end
                else
                begin
                    v = $urandom_range(127, 80);
                    for (k = 0; k < NUM_LEVELS; k++)
                    begin
                        packs[k / HALF_LEVELS][ENTRY_W * (k % HALF_LEVELS) +: ENTRY_W] =
                            ENTRY_W'(v);
                        v = v - $urandom_range(12, 0);
                        v = (v < 0) ? 0 : v;
                    end
                    v = $urandom_range(127, 60);
                    for (k = 0; k < NUM_LEVELS; k++)
                    begin
                        packs[2 + k / HALF_LEVELS][ENTRY_W * (k % HALF_LEVELS) +: ENTRY_W] =
                            ENTRY_W'(v);
                        v = v - $urandom_range(15, 0);
                        v = (v < 0) ? 0 : v;
                    end
                end
                apply_curve(packs[0], packs[1], packs[2], packs[3],
                            TT_W'($urandom_range(15, 0)), 1'(s % 2), 1'((s / 2) % 2));
            end
            soft_sel = (s == 1) || (s >= 2 && ((s / 2) % 2) == 1);

            for (i = 0; i < ITEMS_PER_SETTING; i++)
            begin
                if (i == ITEMS_PER_SETTING / 2)
                begin
                    wait_drained();
                end
                if ($urandom_range(9, 0) == 0)
                begin
                    walk = $urandom_range(127, 0);
                end
                else
                begin
                    walk = walk + $urandom_range(12, 0) - 6;
                    walk = (walk < 0) ? 0 : (walk > 127) ? 127 : walk;
                end
                if ($urandom_range(9, 0) < 3)
                begin
                    raw = RAW_W'((int'(last_duty_seen) * 510 + 100) / 200);
                end
                else
                begin
                    raw = RAW_W'($urandom_range(255, 0));
                end
                if ($urandom_range(9, 0) < (soft_sel ? 5 : 1))
                begin
                    send_item(REQ_TICK, TEMP_W'(walk), raw);
                end
                else
                begin
                    send_item(REQ_SAMPLE, TEMP_W'(walk), raw);
                end
            end
        end

        in_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d samples and %0d ramp ticks across %0d curve settings",
                 samples_sent, ticks_sent, settings_used);
        $display("compared %0d duty results, %0d of them pwm writes", results_seen, pwm_writes);
        if (mismatches == 0 && pending == 0)
        begin
            $display("fan_curve_duty_controller_test passed");
        end
        else
        begin
            $display("fan_curve_duty_controller_test failed");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d duty results outstanding", pending);
        $display("fan_curve_duty_controller_test failed");
        $finish;
    end

endmodule

// ===== fan_curve_duty_controller.f =====
hw/rtl/fcdc_pkg.sv
hw/rtl/fcdc_ctrl.sv
hw/rtl/fcdc_dp.sv
hw/rtl/fan_curve_duty_controller.sv
tb/fan_curve_duty_controller_checker.sv
tb/fan_curve_duty_controller_test.sv
